/* sv/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and defaults of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int MAX_ADVANCES_DEF = 64;

  localparam int MODE_W  = 3;
  localparam int TIME_W  = 16;
  localparam int IDX_W   = 4;
  localparam int SPR_W   = 16;
  localparam int DUR_W   = 16;
  localparam int FRAME_W = 4;
  localparam int CNT_W   = 5;
  localparam int ACC_W   = 32;
  localparam int ENTRY_W = SPR_W + DUR_W;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ENABLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_SCALE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_IN_USE = 2'd2;

  localparam logic [TIME_W-1:0] SPEED_RESET = 16'd256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADV,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic adv;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic covered;
    logic stop_hit;
    logic steps_last;
  } dp_stat_t;

endpackage

/* sv/sfs_ctrl.sv */
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer FSM: accept, command execute, frame advance loop, result hand-off.
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  sfs_pkg::dp_stat_t stat,
  output sfs_pkg::ctl_cmd_t cmd
);

  sfs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = sfs_pkg::S_EXEC;
      end
      sfs_pkg::S_EXEC: begin
        if (stat.tick_go) state_nxt = sfs_pkg::S_ADV;
        else              state_nxt = sfs_pkg::S_WAIT;
      end
      sfs_pkg::S_ADV: begin
        if (!stat.covered || stat.stop_hit || stat.steps_last) state_nxt = sfs_pkg::S_OUT;
      end
      sfs_pkg::S_WAIT: begin
        state_nxt = sfs_pkg::S_OUT;
      end
      sfs_pkg::S_OUT: begin
        if (slot_free) state_nxt = sfs_pkg::S_IDLE;
      end
      default: state_nxt = sfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      sfs_pkg::S_EXEC: cmd.exec     = 1'b1;
      sfs_pkg::S_ADV:  cmd.adv      = 1'b1;
      sfs_pkg::S_WAIT: cmd          = '0;
      sfs_pkg::S_OUT:  cmd.out_load = slot_free;
      default:         cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready)   out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == sfs_pkg::S_EXEC))
    else $error("accepted beat did not enter execute");

  a_out_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("pending result lost");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == sfs_pkg::S_IDLE))
    else $error("ready outside idle");

endmodule

/* sv/sfs_dp.sv */
// ----------------------------------------------------------------------------
// sfs_dp
// Datapath: config registers, frame table, accumulator, frame counter, result.
// ----------------------------------------------------------------------------
module sfs_dp #(
  parameter int TABLE_DEPTH  = sfs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_ADVANCES = sfs_pkg::MAX_ADVANCES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfs_pkg::ctl_cmd_t              cmd,
  output sfs_pkg::dp_stat_t              stat,
  // [15:0] delta_time, [19:16] entry_index, [35:20] entry_sprite, [51:36] entry_duration
  input  logic [sfs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [sfs_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // [15:0] sprite_id, [19:16] frame_index, [20] is_playing, [21] is_finished
  output logic [sfs_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] sprite_valid
  output logic [sfs_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(MAX_ADVANCES + 1);

  function automatic logic [sfs_pkg::DUR_W-1:0] dur_q(input logic [sfs_pkg::ENTRY_W-1:0] e);
    dur_q = e[sfs_pkg::DUR_W-1:0];
  endfunction

  logic [sfs_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [sfs_pkg::ENTRY_W-1:0] rd_q;

  logic                        loop_r;
  logic [sfs_pkg::TIME_W-1:0]  speed_r;
  logic [sfs_pkg::CNT_W-1:0]   fiu_r;

  logic [sfs_pkg::MODE_W-1:0]  mode_r;
  logic [sfs_pkg::IDX_W-1:0]   idx_r;
  logic [sfs_pkg::SPR_W-1:0]   spr_r;
  logic [sfs_pkg::DUR_W-1:0]   dur_r;
  logic [sfs_pkg::ACC_W-1:0]   prod_r;

  logic [sfs_pkg::FRAME_W-1:0] cur_r, cur_nxt;
  logic [sfs_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                        play_r, play_nxt;
  logic                        fin_r, fin_nxt;
  logic [SW-1:0]               steps_r, steps_nxt;

  logic [sfs_pkg::OUT_DATA_W-1:0] odata_r;
  logic [sfs_pkg::OUT_USER_W-1:0] ouser_r;

  logic [8:0]                  depth9, fiu9, idx9, cur9;
  logic [sfs_pkg::CNT_W-1:0]   cnt;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic                        wr_en;
  logic [sfs_pkg::ACC_W-1:0]   need;
  logic [sfs_pkg::ACC_W:0]     sum;
  logic [sfs_pkg::CNT_W-1:0]   nxt_frame;
  logic                        wrap;
  logic                        active;

  assign depth9 = 9'(TABLE_DEPTH);
  assign fiu9   = {4'b0, fiu_r};
  assign cnt    = (fiu9 > depth9) ? depth9[sfs_pkg::CNT_W-1:0] : fiu_r;
  assign active = play_r && !fin_r && (cnt != '0);

  assign need      = {8'b0, dur_q(rd_q), 8'b0};
  assign sum       = {1'b0, acc_r} + {1'b0, prod_r};
  assign nxt_frame = {1'b0, cur_r} + 5'd1;
  assign wrap      = nxt_frame >= cnt;

  assign stat.tick_go    = (mode_r == sfs_pkg::MODE_TICK) && active;
  assign stat.covered    = acc_r >= need;
  assign stat.stop_hit   = wrap && !loop_r;
  assign stat.steps_last = steps_r == SW'(MAX_ADVANCES - 1);

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r  <= 1'b0;
      speed_r <= sfs_pkg::SPEED_RESET;
      fiu_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfs_pkg::REG_LOOP_ENABLE:   loop_r  <= cfg_wdata[0];
        sfs_pkg::REG_SPEED_SCALE:   speed_r <= cfg_wdata;
        sfs_pkg::REG_FRAMES_IN_USE: fiu_r   <= cfg_wdata[sfs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat and scaled delta
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_tuser[sfs_pkg::MODE_W-1:0];
      idx_r  <= in_tdata[19:16];
      spr_r  <= in_tdata[35:20];
      dur_r  <= in_tdata[51:36];
      prod_r <= {16'b0, in_tdata[15:0]} * {16'b0, speed_r};
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    acc_nxt   = acc_r;
    play_nxt  = play_r;
    fin_nxt   = fin_r;
    steps_nxt = steps_r;
    if (cmd.exec) begin
      case (mode_r)
        sfs_pkg::MODE_TICK: begin
          if (active) acc_nxt = sum[sfs_pkg::ACC_W] ? '1 : sum[sfs_pkg::ACC_W-1:0];
          steps_nxt = '0;
        end
        sfs_pkg::MODE_PLAY: begin
          play_nxt = 1'b1;
          fin_nxt  = 1'b0;
        end
        sfs_pkg::MODE_STOP: play_nxt = 1'b0;
        sfs_pkg::MODE_RESTART: begin
          cur_nxt  = '0;
          acc_nxt  = '0;
          play_nxt = 1'b1;
          fin_nxt  = 1'b0;
        end
        sfs_pkg::MODE_LOAD: begin
          cur_nxt  = '0;
          acc_nxt  = '0;
          play_nxt = 1'b0;
          fin_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.adv && stat.covered) begin
      acc_nxt   = acc_r - need;
      steps_nxt = steps_r + SW'(1);
      if (!wrap) begin
        cur_nxt = nxt_frame[sfs_pkg::FRAME_W-1:0];
      end else if (loop_r) begin
        cur_nxt = '0;
      end else begin
        cur_nxt  = sfs_pkg::FRAME_W'(cnt - 5'd1);
        play_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      acc_r   <= '0;
      play_r  <= 1'b0;
      fin_r   <= 1'b0;
      steps_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      acc_r   <= acc_nxt;
      play_r  <= play_nxt;
      fin_r   <= fin_nxt;
      steps_r <= steps_nxt;
    end
  end

  // frame table, read tracks the next frame so rd_q follows cur_r
  assign idx9    = {5'b0, idx_r};
  assign cur9    = {5'b0, cur_nxt};
  assign rd_addr = cur9[AW-1:0];
  assign wr_addr = idx9[AW-1:0];
  assign wr_en   = cmd.exec && (mode_r == sfs_pkg::MODE_LOAD) && (idx9 < depth9);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {spr_r, dur_r};
    rd_q <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r[15:0]  <= (cnt != '0) ? rd_q[sfs_pkg::ENTRY_W-1:sfs_pkg::DUR_W] : '0;
      odata_r[19:16] <= cur_r;
      odata_r[20]    <= play_r;
      odata_r[21]    <= fin_r;
      odata_r[23:22] <= 2'b0;
      ouser_r        <= (cnt != '0);
    end
  end

  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

  a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_r) < TABLE_DEPTH)
    else $error("current frame outside table");

  a_fin_not_play: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> !play_r)
    else $error("finished while playing");

  a_adv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> (32'(steps_r) < MAX_ADVANCES))
    else $error("advance limit exceeded");

endmodule

/* sv/sprite_frame_sequencer.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Animation frame sequencer: steps a sprite/duration table on scaled ticks.
// ----------------------------------------------------------------------------
//  port group   dir  content
//  in_*         in   tuser: mode; tdata: delta_time, entry_index, sprite, duration
//  out_*        out  tuser: sprite_valid; tdata: sprite_id, frame_index, flags
//  cfg_*        in   write-only: loop_enable, speed_scale, frames_in_use
//
//  Play, stop, restart, load, unused modes and idle ticks pass through accept,
//  execute, table read and result load.
//  A tick with N frame advances runs accept, execute, one advance per cycle,
//  then result load; the advance loop ends on a frame not covered, on an
//  advance that stops the run, or at MAX_ADVANCES (N <= MAX_ADVANCES).
//  Reset: rst_n synchronous; the frame table is not cleared.
//  A new beat is taken while the previous result waits on out_tready; the
//  next result load then waits for that slot.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int TABLE_DEPTH  = sfs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_ADVANCES = sfs_pkg::MAX_ADVANCES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] delta_time, [19:16] entry_index, [35:20] entry_sprite, [51:36] entry_duration
  input  logic [sfs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [sfs_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] sprite_id, [19:16] frame_index, [20] is_playing, [21] is_finished
  output logic [sfs_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] sprite_valid
  output logic [sfs_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sfs_pkg::ctl_cmd_t cmd;
  sfs_pkg::dp_stat_t stat;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_ADVANCES(MAX_ADVANCES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

endmodule
